/* design/lis_pkg.sv */
package lis_pkg;

  // Most results given for one sequence
  localparam int unsigned RESULT_LIMIT = 64;

  // Control tag that travels with an element down the cell row
  typedef struct packed {
    logic valid;   // slot carries an element
    logic done;    // element has found its pile
    logic top;     // element became the tail of the top pile
    logic opened;  // element opened a new pile
  } lis_tag_t;

  // Sequence status from the input side to the backtrack controller
  typedef struct packed {
    logic final_in;  // last element of the sequence accepted this cycle
    logic dropped;   // an element was dropped for lack of capacity
  } lis_seq_t;

  // Controller status back to the input side and the cell row
  typedef struct packed {
    logic accepting;  // input channel may take a transaction
    logic clear;      // drop all sequence state
  } lis_ctl_t;

  // Backtrack controller states
  typedef enum logic [6:0] {
    ST_RUN      = 7'b0000001,
    ST_DRAIN    = 7'b0000010,
    ST_WALK_RD  = 7'b0000100,
    ST_WALK_WR  = 7'b0001000,
    ST_EMIT_RD  = 7'b0010000,
    ST_EMIT_PUT = 7'b0100000,
    ST_CLEAR    = 7'b1000000
  } lis_state_e;

endpackage

/* design/lis_if.sv */
interface lis_in_if #(
  parameter int unsigned DW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] sample_value;
  logic                 is_final;

  modport source (output valid, sample_value, is_final, input ready);
  modport sink   (input valid, sample_value, is_final, output ready);
endinterface

interface lis_out_if #(
  parameter int unsigned DW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] run_value;
  logic                 run_end;
  logic                 overflow_seen;

  modport source (output valid, run_value, run_end, overflow_seen, input ready);
  modport sink   (input valid, run_value, run_end, overflow_seen, output ready);
endinterface

/* design/lis_cell.sv */
module lis_cell #(
  parameter int unsigned DW    = 32,
  parameter int unsigned IDX_W = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  lis_pkg::lis_tag_t    tag_i,
  input  logic signed [DW-1:0] value_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [IDX_W-1:0]     pred_i,
  input  logic                 next_occ_i,
  output logic                 occ_o,
  output lis_pkg::lis_tag_t    tag_o,
  output logic signed [DW-1:0] value_o,
  output logic [IDX_W-1:0]     idx_o,
  output logic [IDX_W-1:0]     pred_o
);

  logic                 valid_q;
  logic signed [DW-1:0] tail_q;
  logic [IDX_W-1:0]     pos_q;
  lis_pkg::lis_tag_t    tag_q;
  logic signed [DW-1:0] value_q;
  logic [IDX_W-1:0]     idx_q;
  logic [IDX_W-1:0]     pred_q;

  logic hit, open, ge, land, lower, pass;

  // Compare the passing element against this pile's tail
  assign hit   = tag_i.valid && !tag_i.done;
  assign open  = hit && !valid_q;
  assign ge    = valid_q && (tail_q >= value_i);
  assign land  = hit && ge;
  assign lower = land && (value_i < tail_q);
  assign pass  = hit && valid_q && !ge;

  // Pile is in use now or is being opened this cycle
  assign occ_o = valid_q | open;

  // Hold the pile state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (open) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (open || lower) begin
      tail_q <= value_i;
      pos_q  <= idx_i;
    end
  end

  // Advance the element to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q.valid  <= tag_i.valid;
      tag_q.done   <= tag_i.done | open | land;
      tag_q.top    <= tag_i.top | open | (lower && !next_occ_i);
      tag_q.opened <= tag_i.opened | open;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_i;
    idx_q   <= idx_i;
    pred_q  <= pass ? pos_q : pred_i;
  end

  assign tag_o   = tag_q;
  assign value_o = value_q;
  assign idx_o   = idx_q;
  assign pred_o  = pred_q;

endmodule

/* design/lis_chain.sv */
module lis_chain #(
  parameter int unsigned DW        = 32,
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned IDX_W     = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  lis_pkg::lis_tag_t    tag_i,
  input  logic signed [DW-1:0] value_i,
  input  logic [IDX_W-1:0]     idx_i,
  output lis_pkg::lis_tag_t    tag_o,
  output logic signed [DW-1:0] value_o,
  output logic [IDX_W-1:0]     idx_o,
  output logic [IDX_W-1:0]     pred_o
);

  lis_pkg::lis_tag_t    tag_w   [MAX_ITEMS+1];
  logic signed [DW-1:0] value_w [MAX_ITEMS+1];
  logic [IDX_W-1:0]     idx_w   [MAX_ITEMS+1];
  logic [IDX_W-1:0]     pred_w  [MAX_ITEMS+1];
  logic                 occ_w   [MAX_ITEMS+1];

  // Feed the row; the predecessor is filled in along the way
  assign tag_w[0]   = tag_i;
  assign value_w[0] = value_i;
  assign idx_w[0]   = idx_i;
  assign pred_w[0]  = '0;

  // No pile beyond the last cell
  assign occ_w[MAX_ITEMS] = 1'b0;

  // One cell per pile
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    lis_cell #(
      .DW    (DW),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (clear_i),
      .tag_i      (tag_w[k]),
      .value_i    (value_w[k]),
      .idx_i      (idx_w[k]),
      .pred_i     (pred_w[k]),
      .next_occ_i (occ_w[k+1]),
      .occ_o      (occ_w[k]),
      .tag_o      (tag_w[k+1]),
      .value_o    (value_w[k+1]),
      .idx_o      (idx_w[k+1]),
      .pred_o     (pred_w[k+1])
    );
  end

  assign tag_o   = tag_w[MAX_ITEMS];
  assign value_o = value_w[MAX_ITEMS];
  assign idx_o   = idx_w[MAX_ITEMS];
  assign pred_o  = pred_w[MAX_ITEMS];

endmodule

/* design/lis_emit.sv */
module lis_emit #(
  parameter int unsigned DW        = 32,
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned CNT_W     = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lis_pkg::lis_tag_t    exit_tag_i,
  input  logic signed [DW-1:0] exit_value_i,
  input  logic [IDX_W-1:0]     exit_idx_i,
  input  logic [IDX_W-1:0]     exit_pred_i,
  input  lis_pkg::lis_seq_t    seq_i,
  output lis_pkg::lis_ctl_t    ctl_o,
  lis_out_if.source            out_o
);

  localparam int unsigned OUT_MAX =
    (MAX_ITEMS < lis_pkg::RESULT_LIMIT) ? MAX_ITEMS : lis_pkg::RESULT_LIMIT;
  localparam int unsigned OUT_W = $clog2(OUT_MAX + 1);

  // Element store, predecessor links and the forward-order run buffer
  logic signed [DW-1:0] val_mem  [MAX_ITEMS];
  logic [IDX_W-1:0]     pred_mem [MAX_ITEMS];
  logic signed [DW-1:0] run_mem  [MAX_ITEMS];

  lis_pkg::lis_state_e  state_q, state_d;
  logic [CNT_W-1:0]     drain_q;
  logic [CNT_W-1:0]     len_q;
  logic [IDX_W-1:0]     top_q;
  logic [CNT_W-1:0]     walk_k_q;
  logic [IDX_W-1:0]     walk_idx_q;
  logic [OUT_W-1:0]     emit_q;
  logic signed [DW-1:0] rd_val_q;
  logic [IDX_W-1:0]     rd_pred_q;
  logic signed [DW-1:0] run_rd_q;
  logic                 out_valid_q;
  logic signed [DW-1:0] out_value_q;
  logic                 out_end_q;
  logic                 out_ovf_q;

  logic [OUT_W-1:0] emit_n;
  logic             emit_last;
  logic             load;
  logic             clear;

  // Number of results for this sequence, capped
  assign emit_n    = (len_q > CNT_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(len_q);
  assign emit_last = ((emit_q + OUT_W'(1)) == emit_n);
  assign clear     = (state_q == lis_pkg::ST_CLEAR);

  // Sequence control
  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    case (state_q)
      lis_pkg::ST_RUN: begin
        if (seq_i.final_in) state_d = lis_pkg::ST_DRAIN;
      end
      lis_pkg::ST_DRAIN: begin
        if (drain_q == CNT_W'(MAX_ITEMS)) begin
          state_d = (len_q == '0) ? lis_pkg::ST_CLEAR : lis_pkg::ST_WALK_RD;
        end
      end
      lis_pkg::ST_WALK_RD: begin
        state_d = lis_pkg::ST_WALK_WR;
      end
      lis_pkg::ST_WALK_WR: begin
        state_d = (walk_k_q == CNT_W'(1)) ? lis_pkg::ST_EMIT_RD : lis_pkg::ST_WALK_RD;
      end
      lis_pkg::ST_EMIT_RD: begin
        state_d = lis_pkg::ST_EMIT_PUT;
      end
      lis_pkg::ST_EMIT_PUT: begin
        if (!out_valid_q || out_o.ready) begin
          load    = 1'b1;
          state_d = emit_last ? lis_pkg::ST_CLEAR : lis_pkg::ST_EMIT_RD;
        end
      end
      lis_pkg::ST_CLEAR: begin
        state_d = lis_pkg::ST_RUN;
      end
      default: begin
        state_d = lis_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lis_pkg::ST_RUN;
      drain_q     <= '0;
      len_q       <= '0;
      top_q       <= '0;
      walk_k_q    <= '0;
      walk_idx_q  <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Count the cycles the row needs to empty
      if (state_q == lis_pkg::ST_DRAIN) begin
        drain_q <= drain_q + CNT_W'(1);
      end else begin
        drain_q <= '0;
      end

      // Track pile count and top tail from elements leaving the row
      if (clear) begin
        len_q <= '0;
        top_q <= '0;
      end else if (exit_tag_i.valid) begin
        if (exit_tag_i.opened) len_q <= len_q + CNT_W'(1);
        if (exit_tag_i.top)    top_q <= exit_idx_i;
      end

      // Walk the predecessor links from the top tail
      if (state_q == lis_pkg::ST_DRAIN) begin
        walk_k_q   <= len_q;
        walk_idx_q <= top_q;
        emit_q     <= '0;
      end else if (state_q == lis_pkg::ST_WALK_WR) begin
        walk_k_q   <= walk_k_q - CNT_W'(1);
        walk_idx_q <= rd_pred_q;
      end else if (load) begin
        emit_q <= emit_q + OUT_W'(1);
      end

      // Output register handshake
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Store elements and links as they leave the row
  always_ff @(posedge clk_i) begin
    if (exit_tag_i.valid) begin
      val_mem[exit_idx_i]  <= exit_value_i;
      pred_mem[exit_idx_i] <= exit_pred_i;
    end
    rd_val_q  <= val_mem[walk_idx_q];
    rd_pred_q <= pred_mem[walk_idx_q];
  end

  // Reverse the walked chain into forward order
  always_ff @(posedge clk_i) begin
    if (state_q == lis_pkg::ST_WALK_WR) begin
      run_mem[IDX_W'(walk_k_q - CNT_W'(1))] <= rd_val_q;
    end
    run_rd_q <= run_mem[IDX_W'(emit_q)];
  end

  // Load a result
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_value_q <= run_rd_q;
      out_end_q   <= emit_last;
      out_ovf_q   <= seq_i.dropped;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.run_value     = out_value_q;
  assign out_o.run_end       = out_end_q;
  assign out_o.overflow_seen = out_ovf_q;

  assign ctl_o.accepting = (state_q == lis_pkg::ST_RUN);
  assign ctl_o.clear     = clear;

  // Pile count stays within the row
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(MAX_ITEMS))
    else $error("pile count beyond cell row");

  // Every element leaving the row has found a pile
  a_exit_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_tag_i.valid |-> exit_tag_i.done)
    else $error("element left the row unplaced");

  // Elements leave the row only before the backtrack starts
  a_exit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_tag_i.valid |-> (state_q == lis_pkg::ST_RUN || state_q == lis_pkg::ST_DRAIN))
    else $error("element left the row during backtrack");

  // Walk never runs past the chain start
  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lis_pkg::ST_WALK_WR) |-> (walk_k_q != '0))
    else $error("backtrack step with empty count");

  // A new result appears only from the emit step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lis_pkg::ST_EMIT_PUT))
    else $error("result loaded outside emit step");

endmodule

/* design/longest_increasing_subsequence_core.sv */
// Channel   Dir  Interface          Payload
// in_i      in   lis_in_if.sink     sample_value, is_final
// out_o     out  lis_out_if.source  run_value, run_end, overflow_seen
//
// One element is accepted per cycle while a sequence is collected; each
// element walks the row of MAX_ITEMS pile cells, one cell per cycle.
// After the last element the row is emptied, then ST_WALK_RD and ST_WALK_WR follow
// one link per subsequence element, ST_EMIT_RD and ST_EMIT_PUT give each result, and ST_CLEAR ends it.
// Reset is asynchronous; the input is held off from the last element until
// the clear state is over. A stalled output holds its result and stops the emit step.
module longest_increasing_subsequence_core #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lis_in_if.sink      in_i,
  lis_out_if.source   out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] count_q;
  logic             drop_q;
  logic             accept;
  logic             store;

  lis_pkg::lis_ctl_t    ctl;
  lis_pkg::lis_seq_t    seq;
  lis_pkg::lis_tag_t    entry_tag;
  lis_pkg::lis_tag_t    exit_tag;
  logic signed [DATA_WIDTH-1:0] exit_value;
  logic [IDX_W-1:0]     exit_idx;
  logic [IDX_W-1:0]     exit_pred;

  // Accept a transaction; store it while capacity remains
  assign in_i.ready = ctl.accepting;
  assign accept     = in_i.valid && in_i.ready;
  assign store      = accept && (count_q != CNT_W'(MAX_ITEMS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (ctl.clear) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      if (store) count_q <= count_q + CNT_W'(1);
      if (accept && !store) drop_q <= 1'b1;
    end
  end

  assign entry_tag.valid  = store;
  assign entry_tag.done   = 1'b0;
  assign entry_tag.top    = 1'b0;
  assign entry_tag.opened = 1'b0;

  assign seq.final_in = accept && in_i.is_final;
  assign seq.dropped  = drop_q;

  // Pile cells
  lis_chain #(
    .DW        (DATA_WIDTH),
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (ctl.clear),
    .tag_i   (entry_tag),
    .value_i (in_i.sample_value),
    .idx_i   (count_q[IDX_W-1:0]),
    .tag_o   (exit_tag),
    .value_o (exit_value),
    .idx_o   (exit_idx),
    .pred_o  (exit_pred)
  );

  // Backtrack and result output
  lis_emit #(
    .DW        (DATA_WIDTH),
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .exit_tag_i   (exit_tag),
    .exit_value_i (exit_value),
    .exit_idx_i   (exit_idx),
    .exit_pred_i  (exit_pred),
    .seq_i        (seq),
    .ctl_o        (ctl),
    .out_o        (out_o)
  );

endmodule

/* bench/tb_longest_increasing_subsequence_core.sv */
`timescale 1ns / 100ps

module tb_longest_increasing_subsequence_core;

  localparam int unsigned MAX_ITEMS  = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam logic signed [DATA_WIDTH-1:0] INT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_WIDTH-1:0] INT_MIN = 32'sh8000_0000;
  localparam int unsigned DRAIN_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 4 * MAX_ITEMS;

  typedef logic signed [DATA_WIDTH-1:0] sample_t;

  // One emitted element of the subsequence
  typedef struct {
    sample_t run_value;
    logic    run_end;
    logic    overflow_seen;
  } lis_result_t;

  logic clk;
  logic rst_n;

  lis_in_if  #(.DW(DATA_WIDTH)) sample_bus ();
  lis_out_if #(.DW(DATA_WIDTH)) run_bus ();

  longest_increasing_subsequence_core #(
    .MAX_ITEMS (MAX_ITEMS),
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (sample_bus),
    .out_o (run_bus)
  );

  // Shadow of the pile table, rebuilt on every accepted element
  sample_t seq_store [MAX_ITEMS];
  sample_t pile_tail [MAX_ITEMS];
  int      pile_pos  [MAX_ITEMS];
  int      back_link [MAX_ITEMS];
  int      seq_len;
  int      pile_count;
  bit      seq_dropped;

  lis_result_t subseq_expected [$];
  int          error_count;
  bit          in_idle_on;
  bit          out_idle_on;

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard limit on the run
  initial begin
    #(10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic int pick_gap(input bit idle_on);
    return idle_on ? int'($urandom_range(0, 19)) : 0;
  endfunction

  // Place one element in the pile table; on the last one, queue the subsequence
  function automatic void lis_predict(input sample_t v, input logic fin);
    int      lo;
    int      hi;
    int      mid;
    int      idx;
    int      n;
    sample_t chain [$];
    lis_result_t r;
    if (seq_len >= MAX_ITEMS) begin
      seq_dropped = 1'b1;
    end else begin
      lo = 0;
      hi = pile_count;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (pile_tail[mid] >= v) hi = mid;
        else lo = mid + 1;
      end
      idx = seq_len;
      seq_store[idx] = v;
      back_link[idx] = (lo > 0) ? pile_pos[lo - 1] : MAX_ITEMS;
      if (lo == pile_count) begin
        pile_tail[lo] = v;
        pile_pos[lo] = idx;
        pile_count++;
      end else if (v < pile_tail[lo]) begin
        pile_tail[lo] = v;
        pile_pos[lo] = idx;
      end
      seq_len++;
    end
    if (fin) begin
      if (pile_count > 0) begin
        idx = pile_pos[pile_count - 1];
        for (int k = 0; k < pile_count; k++) begin
          chain.push_front(seq_store[idx]);
          idx = back_link[idx];
        end
      end
      n = (chain.size() > lis_pkg::RESULT_LIMIT) ? lis_pkg::RESULT_LIMIT : chain.size();
      for (int k = 0; k < n; k++) begin
        r.run_value = chain[k];
        r.run_end = (k == n - 1);
        r.overflow_seen = seq_dropped;
        subseq_expected.insert(subseq_expected.size(), r);
      end
      seq_len = 0;
      pile_count = 0;
      seq_dropped = 1'b0;
    end
  endfunction

  // Send one element and wait for its transaction
  task automatic send_sample(input sample_t v, input logic fin);
    int gap;
    gap = pick_gap(in_idle_on);
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.sample_value <= v;
    sample_bus.is_final <= fin;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    lis_predict(v, fin);
  endtask

  task automatic send_sequence(input sample_t vals [$]);
    foreach (vals[k]) begin
      send_sample(vals[k], k == vals.size() - 1);
    end
  endtask

  // Hold the sender until every queued result has come out
  task automatic wait_results_drained();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (subseq_expected.size() != 0) @(posedge clk);
  endtask

  // Output side: stall a random number of cycles per result
  initial begin
    int stall;
    run_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pick_gap(out_idle_on);
      if (stall > 0) begin
        run_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      run_bus.ready <= 1'b1;
      @(posedge clk);
      while (!run_bus.valid) @(posedge clk);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    lis_result_t want;
    if (run_bus.valid === 1'b1 && run_bus.ready === 1'b1) begin
      if (subseq_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result run_value=%0d run_end=%0b",
                                  run_bus.run_value, run_bus.run_end));
      end else begin
        want = subseq_expected.pop_front();
        if (run_bus.run_value !== want.run_value)
          report_mismatch($sformatf("run_value %0d, want %0d",
                                    run_bus.run_value, want.run_value));
        if (run_bus.run_end !== want.run_end)
          report_mismatch($sformatf("run_end %0b, want %0b (run_value %0d)",
                                    run_bus.run_end, want.run_end, want.run_value));
        if (run_bus.overflow_seen !== want.overflow_seen)
          report_mismatch($sformatf("overflow_seen %0b, want %0b (run_value %0d)",
                                    run_bus.overflow_seen, want.overflow_seen,
                                    want.run_value));
      end
    end
  end

  // Mixed value draw: full range, small values, both ends of the range
  function automatic sample_t draw_value();
    case ($urandom_range(0, 4))
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(0, 16)) - 8);
      2: return INT_MIN + sample_t'($urandom_range(0, 3));
      3: return INT_MAX - sample_t'($urandom_range(0, 3));
      default: return sample_t'(int'($urandom_range(0, 1000)) - 500);
    endcase
  endfunction

  task automatic test_single_element();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    send_sequence('{INT_MAX});
  endtask

  task automatic test_range_extremes();
    send_sequence('{INT_MIN, -32'sd1, 32'sd0, 32'sd1, INT_MAX});
  endtask

  task automatic test_equal_values();
    send_sequence('{32'sd5, 32'sd5, 32'sd5});
  endtask

  task automatic test_descending();
    send_sequence('{INT_MAX, 32'sd100, 32'sd0, -32'sd100, INT_MIN});
  endtask

  task automatic test_mixed_order();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    send_sequence('{32'sd3, 32'sd1, 32'sd4, 32'sd1, 32'sd5, 32'sd9, 32'sd2, 32'sd6});
  endtask

  // Fill the store exactly, then overrun it so the last three elements are dropped
  task automatic test_capacity();
    sample_t vals [$];
    sample_t v;
    wait_results_drained();
    in_idle_on = 1'b0;
    out_idle_on = 1'b1;
    v = INT_MIN + sample_t'($urandom_range(0, 15));
    for (int k = 0; k < MAX_ITEMS; k++) begin
      vals.insert(vals.size(), v);
      v = v + sample_t'($urandom_range(1, 1 << 25));
    end
    send_sequence(vals);
    in_idle_on = 1'b1;
    out_idle_on = 1'b0;
    vals.delete();
    for (int k = 0; k < MAX_ITEMS + 3; k++) begin
      vals.insert(vals.size(), draw_value());
    end
    send_sequence(vals);
  endtask

  // Random sequences: random values, rising walks, dense duplicates
  task automatic test_random_sequences();
    sample_t vals [$];
    sample_t v;
    int      sent;
    int      len;
    int      style;
    int      seq_no;
    sent = 0;
    seq_no = 0;
    while (sent < 105) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      style = $urandom_range(0, 2);
      vals.delete();
      v = draw_value();
      for (int k = 0; k < len; k++) begin
        case (style)
          0: v = draw_value();
          1: v = v + sample_t'(int'($urandom_range(0, 64)) - 16);
          default: v = sample_t'(int'($urandom_range(0, 7)) - 3);
        endcase
        vals.insert(vals.size(), v);
      end
      send_sequence(vals);
      sent += len;
      seq_no++;
      if (seq_no == 4) wait_results_drained();
    end
  endtask

  // Drain, settle and give the verdict
  task automatic finish_run();
    int waited;
    sample_bus.valid <= 1'b0;
    waited = 0;
    while (subseq_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (subseq_expected.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", subseq_expected.size()));
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  endtask

  initial begin
    error_count = 0;
    seq_len = 0;
    pile_count = 0;
    seq_dropped = 1'b0;
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    rst_n = 1'b0;
    sample_bus.valid <= 1'b0;
    sample_bus.sample_value <= '0;
    sample_bus.is_final <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_element();
    test_range_extremes();
    test_equal_values();
    test_descending();
    test_mixed_order();
    test_capacity();
    test_random_sequences();
    finish_run();
  end

endmodule
